/* src/sfd_pkg.sv */
package sfd_pkg;

  localparam int RomTaps = 63;

  // q15 low-pass, symmetric, tap 0 applied to the newest sample
  localparam logic signed [15:0] LOWPASS_ROM [RomTaps] = '{
    -16'sd2,    -16'sd4,    -16'sd1,    16'sd8,     16'sd16,    16'sd9,
    -16'sd18,   -16'sd42,   -16'sd31,   16'sd28,    16'sd90,    16'sd81,
    -16'sd28,   -16'sd162,  -16'sd178,  16'sd0,     16'sd259,   16'sd344,
    16'sd86,    -16'sd372,  -16'sd611,  -16'sd283,  16'sd487,   16'sd1047,
    16'sd700,   -16'sd589,  -16'sd1880, -16'sd1747, 16'sd658,   16'sd4754,
    16'sd8643,  16'sd10244, 16'sd8643,  16'sd4754,  16'sd658,   -16'sd1747,
    -16'sd1880, -16'sd589,  16'sd700,   16'sd1047,  16'sd487,   -16'sd283,
    -16'sd611,  -16'sd372,  16'sd86,    16'sd344,   16'sd259,   16'sd0,
    -16'sd178,  -16'sd162,  -16'sd28,   16'sd81,    16'sd90,    16'sd28,
    -16'sd31,   -16'sd42,   -16'sd18,   16'sd9,     16'sd16,    16'sd8,
    -16'sd1,    -16'sd4,    -16'sd2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } sfd_state_t;

  typedef struct packed {
    logic write;     // store the mono mix of the accepted word
    logic start;     // clear accumulator, point reader at newest sample
    logic issue;     // read one history entry and its coefficient
    logic round;     // round and scale the finished sum
    logic out_load;  // saturate into the output register
  } sfd_cmd_t;

  typedef struct packed {
    logic last_tap;  // the current issue is the final tap
    logic out_full;  // output register holds a word not yet taken
  } sfd_status_t;

  // taps past the rom use a zero coefficient
  function automatic logic signed [15:0] tap_coef(input logic [7:0] tap);
    logic signed [15:0] c;
    c = '0;
    if (tap < 8'(RomTaps)) begin
      c = LOWPASS_ROM[tap[5:0]];
    end
    return c;
  endfunction

endpackage

/* src/sfd_ctrl.sv */
module sfd_ctrl #(
  parameter int DECIM_RATIO = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfd_pkg::sfd_status_t status,
  output sfd_pkg::sfd_cmd_t    cmd
);

  localparam int PW = $clog2(DECIM_RATIO + 1);

  sfd_pkg::sfd_state_t state, state_next;
  logic [PW-1:0]       phase, phase_next;
  logic                drain_cnt, drain_cnt_next;
  logic                accept;
  logic                phase_wrap;

  assign in_ready   = (state == sfd_pkg::ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign phase_wrap = (phase + PW'(1)) >= PW'(DECIM_RATIO);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      phase_next = phase_wrap ? '0 : phase + PW'(1);
    end
  end

  always_comb begin
    state_next     = state;
    drain_cnt_next = drain_cnt;
    unique case (state)
      sfd_pkg::ST_IDLE: begin
        if (accept && phase_wrap) begin
          state_next = sfd_pkg::ST_MAC;
        end
      end
      sfd_pkg::ST_MAC: begin
        if (status.last_tap) begin
          state_next     = sfd_pkg::ST_DRAIN;
          drain_cnt_next = 1'b0;
        end
      end
      sfd_pkg::ST_DRAIN: begin
        // wait here while the multiply and accumulate stages empty
        drain_cnt_next = 1'b1;
        if (drain_cnt) begin
          state_next = sfd_pkg::ST_ROUND;
        end
      end
      sfd_pkg::ST_ROUND: begin
        state_next = sfd_pkg::ST_OUT;
      end
      sfd_pkg::ST_OUT: begin
        if (!status.out_full) begin
          state_next = sfd_pkg::ST_IDLE;
        end
      end
      default: state_next = sfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      sfd_pkg::ST_IDLE: begin
        cmd.write = accept;
        cmd.start = accept && phase_wrap;
      end
      sfd_pkg::ST_MAC:   cmd.issue    = 1'b1;
      sfd_pkg::ST_DRAIN: cmd          = '0;
      sfd_pkg::ST_ROUND: cmd.round    = 1'b1;
      sfd_pkg::ST_OUT:   cmd.out_load = !status.out_full;
      default:           cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sfd_pkg::ST_IDLE;
      phase     <= '0;
      drain_cnt <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      drain_cnt <= drain_cnt_next;
    end
  end

  a_wrap_starts_mac: assert property (@(posedge clk) disable iff (rst)
    accept && phase_wrap |=> state == sfd_pkg::ST_MAC)
    else $error("frame completing a decimation period did not start the filter");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    phase < PW'(DECIM_RATIO))
    else $error("decimation phase out of range");

  a_load_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == sfd_pkg::ST_IDLE && !in_ready == 1'b0)
    else $error("output load not followed by idle");

  a_no_issue_outside_mac: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !cmd.write && !cmd.round && !cmd.out_load)
    else $error("filter read overlaps another command");

endmodule

/* src/sfd_datapath.sv */
module sfd_datapath #(
  parameter int TAP_COUNT = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         in_data,
  input  sfd_pkg::sfd_cmd_t    cmd,
  output sfd_pkg::sfd_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_data
);

  localparam int AW    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int ACC_W = 32 + $clog2(TAP_COUNT + 1);
  localparam int QW    = ACC_W - 15;
  localparam logic signed [QW-1:0] QMax = QW'(32767);
  localparam logic signed [QW-1:0] QMin = -QW'(32768);

  logic signed [15:0]    history [TAP_COUNT];
  logic [TAP_COUNT-1:0]  written;
  logic [AW-1:0]         wpos;
  logic [AW-1:0]         rd_pos;
  logic [AW-1:0]         tap;

  logic signed [16:0]    mix_sum;
  logic signed [16:0]    mix_half;
  logic signed [15:0]    mono;

  logic signed [15:0]    rd_data;
  logic                  rd_ok;
  logic signed [15:0]    coef_r;
  logic                  s1_v;
  logic signed [31:0]    prod;
  logic                  s2_v;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [QW-1:0]  q;
  logic signed [15:0]    sample;

  // halve toward zero: bias negative sums by one before the shift
  assign mix_sum  = 17'(signed'(in_data[15:0])) + 17'(signed'(in_data[31:16]));
  assign mix_half = (mix_sum + (mix_sum[16] ? 17'sd1 : 17'sd0)) >>> 1;
  assign mono     = mix_half[15:0];

  assign sample = rd_ok ? rd_data : 16'sd0;

  // round half away from zero in one add, then drop the low 15 bits
  assign acc_sum = acc + (acc[ACC_W-1] ? ACC_W'(16383) : ACC_W'(16384));

  assign status.last_tap = cmd.issue && (tap == AW'(TAP_COUNT - 1));
  assign status.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      history[wpos] <= mono;
    end
    if (cmd.issue) begin
      rd_data <= history[rd_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      wpos      <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
      if (cmd.write) begin
        written[wpos] <= 1'b1;
        wpos <= (wpos == AW'(TAP_COUNT - 1)) ? '0 : wpos + AW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_pos <= wpos;
      tap    <= '0;
      acc    <= '0;
    end else begin
      if (cmd.issue) begin
        rd_pos <= (rd_pos == '0) ? AW'(TAP_COUNT - 1) : rd_pos - AW'(1);
        tap    <= tap + AW'(1);
        rd_ok  <= written[rd_pos];
        coef_r <= sfd_pkg::tap_coef(8'(tap));
      end
      if (s1_v) begin
        prod <= sample * coef_r;
      end
      if (s2_v) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (cmd.round) begin
      q <= acc_sum[ACC_W-1:15];
    end
    if (cmd.out_load) begin
      if (q > QMax) begin
        out_data <= 16'h7fff;
      end else if (q < QMin) begin
        out_data <= 16'h8000;
      end else begin
        out_data <= q[15:0];
      end
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output register overwritten before it was taken");

  a_pipe_follows_issue: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> s1_v ##1 s2_v)
    else $error("multiply pipeline lost a tap");

  a_tap_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> tap <= AW'(TAP_COUNT - 1))
    else $error("tap counter ran past the last tap");

endmodule

/* src/stereo_fir_decimator_by_three.sv */
// stereo to mono decimating fir, 63-tap q15 low-pass, one output per three frames
//
// s_* carries stereo frames, m_* carries the filtered mono words.
// each frame is mixed to mono as (left+right)/2 toward zero and written to a
// TAP_COUNT-entry history ring; every DECIM_RATIO-th frame starts a filter run.
// a frame that does not complete a period is only written to the history.
// a frame that does holds s_tready low while one shared multiply and
// accumulate reads the history memory one tap per cycle, then the multiply
// pipeline empties, one step rounds and one saturates into the output
// register. no frame is taken during a filter run, so a new run cannot
// start before the last one is through. a waiting output word does not
// stop frames coming in; only a second result ready before the first is
// taken stalls, in which case s_tready stays low until m_tready drains
// the output register.
// reset clears the history (per-entry valid bits), ring position, phase and
// the output valid, with no clearing pass.
module stereo_fir_decimator_by_three #(
  parameter int TAP_COUNT   = 63,
  parameter int DECIM_RATIO = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // left_sample [15:0], right_sample [31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // mono_out [15:0]
);

  sfd_pkg::sfd_cmd_t    cmd;
  sfd_pkg::sfd_status_t status;

  sfd_ctrl #(
    .DECIM_RATIO(DECIM_RATIO)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  sfd_datapath #(
    .TAP_COUNT(TAP_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata)
  );

endmodule
